// ----- src/dpkfe_pkg.sv -----
package dpkfe_pkg;

   localparam int MAX_LENGTH_OCTETS_DEFAULT = 4;

   // configuration register indexes
   localparam logic [1:0] CSR_TAG_MASK  = 2'd0;
   localparam logic [1:0] CSR_OUTER_TAG = 2'd1;
   localparam logic [1:0] CSR_VALUE_TAG = 2'd2;

   localparam logic [7:0] TAG_MASK_RESET  = 8'hdf;
   localparam logic [7:0] OUTER_TAG_RESET = 8'h03;
   localparam logic [7:0] VALUE_TAG_RESET = 8'h02;

   // result status codes
   localparam logic [2:0] ST_BYTE    = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_NOTAG   = 3'd2;
   localparam logic [2:0] ST_EARLY   = 3'd3;
   localparam logic [2:0] ST_TOOLONG = 3'd4;

   typedef struct packed {
      logic [7:0] tag_mask;
      logic [7:0] outer_tag;
      logic [7:0] value_tag;
   } cfg_type;

   typedef struct packed {
      logic req_fire;
      logic rsp_stall;
   } flow_type;

endpackage

// ----- src/dpkfe_parser.sv -----
module dpkfe_parser #(
   parameter int MAX_LENGTH_OCTETS = dpkfe_pkg::MAX_LENGTH_OCTETS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  dpkfe_pkg::cfg_type cfg,
   input  dpkfe_pkg::flow_type flow,
   input  logic [7:0]         data_byte,
   input  logic               end_of_stream,
   output logic               rsp_valid,
   output logic [7:0]         rsp_byte_value,
   output logic               rsp_field_kind,
   output logic [2:0]         rsp_status,
   output logic               rsp_last_of_field
);

   localparam int OW = $clog2(MAX_LENGTH_OCTETS + 1);
   localparam logic [6:0] MAX_N = 7'(MAX_LENGTH_OCTETS);

   typedef enum logic [2:0] {
      PH_OUTER,
      PH_VALUE,
      PH_LEN,
      PH_LENX,
      PH_DATA
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] bytes_ff, bytes_in;
   logic [OW-1:0] oct_ff, oct_in;
   logic        field_ff, field_in;

   logic        rsp_valid_ff;
   logic [7:0]  byte_value_ff;
   logic        field_kind_ff;
   logic [2:0]  status_ff;
   logic        last_ff;

   logic        has_res;
   logic [7:0]  res_val;
   logic [2:0]  res_st;
   logic        res_last;
   logic        do_empty;
   logic        do_stop;
   logic [2:0]  stop_st;

   logic [7:0]  tag;
   logic [7:0]  want;
   logic [6:0]  n_oct;
   logic [31:0] shifted;
   logic [OW-1:0] oct_dec;
   logic        is_last;

   assign tag     = data_byte & cfg.tag_mask;
   assign want    = (phase_ff == PH_OUTER) ? cfg.outer_tag : cfg.value_tag;
   assign n_oct   = data_byte[6:0];
   assign shifted = {bytes_ff[23:0], data_byte};
   assign oct_dec = oct_ff - OW'(1);
   assign is_last = (bytes_ff <= 32'd1);

   always_comb begin
      phase_in = phase_ff;
      bytes_in = bytes_ff;
      oct_in   = oct_ff;
      field_in = field_ff;
      has_res  = 1'b0;
      res_val  = 8'd0;
      res_st   = dpkfe_pkg::ST_BYTE;
      res_last = 1'b0;
      do_empty = 1'b0;
      do_stop  = 1'b0;
      stop_st  = dpkfe_pkg::ST_EARLY;

      unique case (phase_ff) inside
         PH_OUTER, PH_VALUE: begin
            if (tag == want) begin
               if (end_of_stream) begin
                  do_stop = 1'b1;
               end else begin
                  phase_in = (phase_ff == PH_OUTER) ? PH_VALUE : PH_LEN;
               end
            end else if (end_of_stream) begin
               do_stop = 1'b1;
               stop_st = dpkfe_pkg::ST_NOTAG;
            end
         end
         PH_LEN: begin
            if (data_byte[7]) begin
               if (n_oct == 7'd0) begin
                  do_empty = 1'b1;
               end else if (n_oct > MAX_N) begin
                  do_stop = 1'b1;
                  stop_st = dpkfe_pkg::ST_TOOLONG;
               end else if (end_of_stream) begin
                  do_stop = 1'b1;
               end else begin
                  bytes_in = 32'd0;
                  oct_in   = OW'(n_oct);
                  phase_in = PH_LENX;
               end
            end else if (data_byte == 8'd0) begin
               do_empty = 1'b1;
            end else if (end_of_stream) begin
               do_stop = 1'b1;
            end else begin
               bytes_in = {24'd0, data_byte};
               phase_in = PH_DATA;
            end
         end
         PH_LENX: begin
            if (bytes_ff[31:24] != 8'd0) begin
               do_stop = 1'b1;
               stop_st = dpkfe_pkg::ST_TOOLONG;
            end else begin
               bytes_in = shifted;
               oct_in   = oct_dec;
               if (oct_dec != '0) begin
                  if (end_of_stream) begin
                     do_stop = 1'b1;
                  end
               end else if (shifted == 32'd0) begin
                  do_empty = 1'b1;
               end else if (end_of_stream) begin
                  do_stop = 1'b1;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            if (end_of_stream && !(is_last && field_ff)) begin
               do_stop = 1'b1;
            end else begin
               has_res  = 1'b1;
               res_val  = data_byte;
               res_last = is_last;
               if (!is_last) begin
                  bytes_in = bytes_ff - 32'd1;
               end else if (!field_ff) begin
                  field_in = 1'b1;
                  bytes_in = 32'd0;
                  phase_in = PH_VALUE;
               end else begin
                  phase_in = PH_OUTER;
                  bytes_in = 32'd0;
                  oct_in   = '0;
                  field_in = 1'b0;
               end
            end
         end
         default: begin
            phase_in = PH_OUTER;
            bytes_in = 32'd0;
            oct_in   = '0;
            field_in = 1'b0;
         end
      endcase

      // an empty modulus moves on to the exponent unless the stream stops here; an empty exponent finishes the key
      if (do_empty) begin
         if (!field_ff && end_of_stream) begin
            do_stop = 1'b1;
         end else begin
            has_res = 1'b1;
            res_st  = dpkfe_pkg::ST_EMPTY;
            if (!field_ff) begin
               field_in = 1'b1;
               phase_in = PH_VALUE;
               bytes_in = 32'd0;
               oct_in   = '0;
            end else begin
               phase_in = PH_OUTER;
               bytes_in = 32'd0;
               oct_in   = '0;
               field_in = 1'b0;
            end
         end
      end

      if (do_stop) begin
         has_res  = 1'b1;
         res_val  = 8'd0;
         res_st   = stop_st;
         res_last = 1'b0;
         phase_in = PH_OUTER;
         bytes_in = 32'd0;
         oct_in   = '0;
         field_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OUTER;
         bytes_ff     <= 32'd0;
         oct_ff       <= '0;
         field_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (flow.req_fire) begin
            phase_ff     <= phase_in;
            bytes_ff     <= bytes_in;
            oct_ff       <= oct_in;
            field_ff     <= field_in;
            rsp_valid_ff <= has_res;
            if (has_res) begin
               byte_value_ff <= res_val;
               field_kind_ff <= field_ff;
               status_ff     <= res_st;
               last_ff       <= res_last;
            end
         end else if (!flow.rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_byte_value    = byte_value_ff;
   assign rsp_field_kind    = field_kind_ff;
   assign rsp_status        = status_ff;
   assign rsp_last_of_field = last_ff;

endmodule

// ----- src/der_public_key_field_extractor.sv -----
// result: an accepted request's result, if it has one, reaches the output register in the next cycle
// throughput: one request per cycle unless a stalled result holds the output register;
// tag compare, length update and byte counter all settle between state and output registers
// reset: synchronous active-high reset returns to the outer tag search and
// restores tag_mask 0xdf, outer_tag 0x03, value_tag 0x02
module der_public_key_field_extractor #(
   parameter int MAX_LENGTH_OCTETS = dpkfe_pkg::MAX_LENGTH_OCTETS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_stream,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_byte_value,
   output logic       rsp_field_kind,
   output logic [2:0] rsp_status,
   output logic       rsp_last_of_field,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   dpkfe_pkg::cfg_type  cfg_ff;
   dpkfe_pkg::flow_type flow;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tag_mask  <= dpkfe_pkg::TAG_MASK_RESET;
         cfg_ff.outer_tag <= dpkfe_pkg::OUTER_TAG_RESET;
         cfg_ff.value_tag <= dpkfe_pkg::VALUE_TAG_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dpkfe_pkg::CSR_TAG_MASK:  cfg_ff.tag_mask  <= csr_data;
            dpkfe_pkg::CSR_OUTER_TAG: cfg_ff.outer_tag <= csr_data;
            dpkfe_pkg::CSR_VALUE_TAG: cfg_ff.value_tag <= csr_data;
            default: ;
         endcase
      end
   end

   // hold requests only while a result sits in the output register and is stalled
   assign req_stall      = rsp_valid && rsp_stall;
   assign flow.req_fire  = req_valid && !req_stall;
   assign flow.rsp_stall = rsp_stall;

   dpkfe_parser #(
      .MAX_LENGTH_OCTETS(MAX_LENGTH_OCTETS)
   ) u_parser (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .flow              (flow),
      .data_byte         (req_data_byte),
      .end_of_stream     (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_byte_value    (rsp_byte_value),
      .rsp_field_kind    (rsp_field_kind),
      .rsp_status        (rsp_status),
      .rsp_last_of_field (rsp_last_of_field)
   );

endmodule

// ----- tb/tb_der_public_key_field_extractor.sv -----
module tb_der_public_key_field_extractor;

   localparam int MAX_OCTS = dpkfe_pkg::MAX_LENGTH_OCTETS_DEFAULT;
   localparam int PHASE_BYTES = 225;
   localparam int HOLD_CYCLES = 120;

   typedef enum logic [2:0] {
      SCAN_OUTER, SCAN_VALUE, LEN_FIRST, LEN_MORE, CONTENT
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       eos;
   } key_byte_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       field_kind;
      logic [2:0] status;
      logic       last_of_field;
   } field_res_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_end_of_stream = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_byte_value;
   logic       rsp_field_kind;
   logic [2:0] rsp_status;
   logic       rsp_last_of_field;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = dpkfe_pkg::CSR_TAG_MASK;
   logic [7:0] csr_data = 8'h00;

   der_public_key_field_extractor i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_byte_value    (rsp_byte_value),
      .rsp_field_kind    (rsp_field_kind),
      .rsp_status        (rsp_status),
      .rsp_last_of_field (rsp_last_of_field),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   key_byte_type    key_stream[$];
   field_res_type   field_results_due[$];

   dpkfe_pkg::cfg_type key_cfg;
   parse_phase_type key_phase;
   logic [31:0]  bytes_left;
   logic [6:0]   octets_left;
   logic         cur_field;

   bit req_fired = 1'b0;
   int mismatches = 0;
   int n_requests = 0;
   int n_content = 0;
   int n_status = 0;
   int n_csr = 0;
   int queued_bytes = 0;
   int tx_tick = 0;
   int rx_tick = 0;
   int hold_left = 0;
   int next_hold = 300;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------- field extraction predictor ----------------

   function automatic void return_to_outer_search();
      key_phase = SCAN_OUTER;
      bytes_left = '0;
      octets_left = '0;
      cur_field = 1'b0;
   endfunction

   function automatic field_res_type abort_key(input logic [2:0] st);
      field_res_type r;
      r = '{8'h00, cur_field, st, 1'b0};
      return_to_outer_search();
      return r;
   endfunction

   // zero length field: modulus moves on to the exponent unless the stream ends there, exponent finishes the key
   function automatic field_res_type empty_length(input logic eos);
      field_res_type r;
      if (cur_field == 1'b0) begin
         if (eos) begin
            return abort_key(dpkfe_pkg::ST_EARLY);
         end
         r = '{8'h00, 1'b0, dpkfe_pkg::ST_EMPTY, 1'b0};
         cur_field = 1'b1;
         key_phase = SCAN_VALUE;
         bytes_left = '0;
         octets_left = '0;
         return r;
      end
      return abort_key(dpkfe_pkg::ST_EMPTY);
   endfunction

   function automatic bit extract_field_byte(input logic [7:0] b, input logic eos,
                                             output field_res_type r);
      logic [7:0] t;
      logic [7:0] want;
      bit         fin;
      bit         got;
      t = b & key_cfg.tag_mask;
      r = '0;
      got = 1'b1;
      case (key_phase) inside
         SCAN_OUTER, SCAN_VALUE: begin
            want = (key_phase == SCAN_OUTER) ? key_cfg.outer_tag : key_cfg.value_tag;
            if (t == want) begin
               if (eos) begin
                  r = abort_key(dpkfe_pkg::ST_EARLY);
               end else begin
                  key_phase = (key_phase == SCAN_OUTER) ? SCAN_VALUE : LEN_FIRST;
                  got = 1'b0;
               end
            end else if (eos) begin
               r = abort_key(dpkfe_pkg::ST_NOTAG);
            end else begin
               got = 1'b0;
            end
         end
         LEN_FIRST: begin
            if (b[7]) begin
               if (b[6:0] == 7'd0) begin
                  r = empty_length(eos);
               end else if (b[6:0] > 7'(MAX_OCTS)) begin
                  r = abort_key(dpkfe_pkg::ST_TOOLONG);
               end else if (eos) begin
                  r = abort_key(dpkfe_pkg::ST_EARLY);
               end else begin
                  bytes_left = '0;
                  octets_left = b[6:0];
                  key_phase = LEN_MORE;
                  got = 1'b0;
               end
            end else if (b == 8'h00) begin
               r = empty_length(eos);
            end else if (eos) begin
               r = abort_key(dpkfe_pkg::ST_EARLY);
            end else begin
               bytes_left = {24'd0, b};
               key_phase = CONTENT;
               got = 1'b0;
            end
         end
         LEN_MORE: begin
            if (bytes_left[31:24] != 8'd0) begin
               r = abort_key(dpkfe_pkg::ST_TOOLONG);
            end else begin
               bytes_left = {bytes_left[23:0], b};
               if (octets_left != 7'd0) octets_left = octets_left - 7'd1;
               if (octets_left != 7'd0) begin
                  if (eos) r = abort_key(dpkfe_pkg::ST_EARLY);
                  else got = 1'b0;
               end else if (bytes_left == 32'd0) begin
                  r = empty_length(eos);
               end else if (eos) begin
                  r = abort_key(dpkfe_pkg::ST_EARLY);
               end else begin
                  key_phase = CONTENT;
                  got = 1'b0;
               end
            end
         end
         CONTENT: begin
            fin = (bytes_left <= 32'd1);
            // only the final exponent byte may carry the end of stream
            if (eos && !(fin && cur_field)) begin
               r = abort_key(dpkfe_pkg::ST_EARLY);
            end else begin
               r = '{b, cur_field, dpkfe_pkg::ST_BYTE, fin};
               if (!fin) begin
                  bytes_left = bytes_left - 32'd1;
               end else if (!cur_field) begin
                  cur_field = 1'b1;
                  bytes_left = '0;
                  key_phase = SCAN_VALUE;
               end else begin
                  return_to_outer_search();
               end
            end
         end
         default: begin
            return_to_outer_search();
            got = 1'b0;
         end
      endcase
      return got;
   endfunction

   // ---------------- request driver ----------------

   always @(negedge clock) begin
      key_byte_type nxt;
      bit calm;
      tx_tick++;
      calm = (tx_tick % 1000) >= 500 && (tx_tick % 1000) < 700;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (key_stream.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
            nxt = key_stream.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= nxt.data;
            req_end_of_stream <= nxt.eos;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------- result receiver ----------------

   always @(negedge clock) begin
      rx_tick++;
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!reset && rx_tick >= next_hold && req_valid) begin
         // long hold-off while requests keep coming, so the block backs up
         hold_left = HOLD_CYCLES;
         next_hold = rx_tick + 900;
         rsp_stall <= 1'b1;
      end else if ((rx_tick % 1000) >= 500 && (rx_tick % 1000) < 700) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 24);
      end
   end

   // ---------------- monitor and checker ----------------

   always @(posedge clock) begin
      field_res_type want;
      field_res_type pred;
      if (reset) begin
         key_cfg = '{dpkfe_pkg::TAG_MASK_RESET, dpkfe_pkg::OUTER_TAG_RESET,
                     dpkfe_pkg::VALUE_TAG_RESET};
         return_to_outer_search();
         field_results_due.delete();
         req_fired = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (field_results_due.size() == 0) begin
               $error("unexpected result: byte_value %0h status %0d", rsp_byte_value,
                      rsp_status);
               mismatches++;
            end else begin
               want = field_results_due.pop_front();
               if (rsp_byte_value !== want.byte_value) begin
                  $error("byte_value: expected %0h, got %0h", want.byte_value,
                         rsp_byte_value);
                  mismatches++;
               end
               if (rsp_field_kind !== want.field_kind) begin
                  $error("field_kind: expected %0d, got %0d", want.field_kind,
                         rsp_field_kind);
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_last_of_field !== want.last_of_field) begin
                  $error("last_of_field: expected %0d, got %0d", want.last_of_field,
                         rsp_last_of_field);
                  mismatches++;
               end
               if (want.status == dpkfe_pkg::ST_BYTE) n_content++;
               else n_status++;
            end
         end
         req_fired = req_valid && !req_stall;
         if (req_fired) begin
            n_requests++;
            if (extract_field_byte(req_data_byte, req_end_of_stream, pred))
               field_results_due.push_back(pred);
         end
         if (csr_valid && csr_ready) begin
            n_csr++;
            case (csr_index)
               dpkfe_pkg::CSR_TAG_MASK:  key_cfg.tag_mask = csr_data;
               dpkfe_pkg::CSR_OUTER_TAG: key_cfg.outer_tag = csr_data;
               dpkfe_pkg::CSR_VALUE_TAG: key_cfg.value_tag = csr_data;
               default: ;
            endcase
         end
      end
   end

   // ---------------- stimulus ----------------

   task automatic push_byte(input logic [7:0] b, input logic eos);
      key_stream.push_back('{b, eos});
      queued_bytes++;
   endtask

   function automatic logic [7:0] matching_byte(input logic [7:0] tag);
      return tag | (8'($urandom) & ~key_cfg.tag_mask);
   endfunction

   task automatic push_filler(input logic [7:0] tag, input int cnt);
      logic [7:0] b;
      repeat (cnt) begin
         for (int k = 0; k < 8; k++) begin
            b = 8'($urandom);
            if ((b & key_cfg.tag_mask) != tag) begin
               push_byte(b, 1'b0);
               break;
            end
         end
      end
   endtask

   task automatic push_length(input int len);
      int n;
      int need;
      logic [31:0] lv;
      lv = len;
      if (len < 128 && $urandom_range(1) == 1) begin
         push_byte(lv[7:0], 1'b0);
      end else if (len == 0 && $urandom_range(1) == 1) begin
         push_byte(8'h80, 1'b0);
      end else begin
         need = (len > 255) ? 2 : 1;
         n = $urandom_range(MAX_OCTS, need);
         push_byte(8'h80 | 8'(n), 1'b0);
         for (int i = n - 1; i >= 0; i--) push_byte(8'(lv >> (8 * i)), 1'b0);
      end
   endtask

   // well-formed key with random content; a broken one is cut short by an end of stream
   task automatic push_key(input bit broken);
      int start;
      int mod_len;
      int exp_len;
      int cut;
      start = key_stream.size();
      push_filler(key_cfg.outer_tag, $urandom_range(3, 0));
      push_byte(matching_byte(key_cfg.outer_tag), 1'b0);
      push_filler(key_cfg.value_tag, $urandom_range(4, 0));
      push_byte(matching_byte(key_cfg.value_tag), 1'b0);
      mod_len = ($urandom_range(99) < 4) ? $urandom_range(300, 129) : $urandom_range(20, 0);
      push_length(mod_len);
      repeat (mod_len) push_byte(8'($urandom), 1'b0);
      push_filler(key_cfg.value_tag, $urandom_range(2, 0));
      push_byte(matching_byte(key_cfg.value_tag), 1'b0);
      exp_len = $urandom_range(4, 0);
      push_length(exp_len);
      repeat (exp_len) push_byte(8'($urandom), 1'b0);
      if (broken) begin
         cut = $urandom_range(key_stream.size() - 1, start);
         while (key_stream.size() > cut + 1) begin
            void'(key_stream.pop_back());
            queued_bytes--;
         end
         key_stream[cut].eos = 1'b1;
      end else begin
         key_stream[key_stream.size() - 1].eos = 1'($urandom_range(1));
      end
   endtask

   task automatic push_sequence();
      int pick;
      int cnt;
      pick = $urandom_range(99);
      if (pick < 65) begin
         push_key(1'b0);
      end else if (pick < 77) begin
         push_key(1'b1);
      end else if (pick < 85) begin
         // long form count beyond what the block supports
         push_byte(matching_byte(key_cfg.outer_tag), 1'b0);
         push_byte(matching_byte(key_cfg.value_tag), 1'b0);
         push_byte(8'($urandom_range(8'hff, 8'h80 + MAX_OCTS + 1)),
                   1'($urandom_range(1)));
      end else if (pick < 90) begin
         // huge four octet length, stream ends inside the content
         push_byte(matching_byte(key_cfg.outer_tag), 1'b0);
         push_byte(matching_byte(key_cfg.value_tag), 1'b0);
         push_byte(8'h84, 1'b0);
         push_byte(8'($urandom_range(8'hff, 8'h80)), 1'b0);
         repeat (3) push_byte(8'($urandom), 1'b0);
         cnt = $urandom_range(6, 1);
         repeat (cnt - 1) push_byte(8'($urandom), 1'b0);
         push_byte(8'($urandom), 1'b1);
      end else begin
         cnt = $urandom_range(8, 1);
         repeat (cnt - 1) push_byte(8'($urandom), 1'b0);
         push_byte(8'($urandom), 1'($urandom_range(1)));
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (key_stream.size() != 0 || req_valid || field_results_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      // {end of stream, byte}
      logic [8:0] directed [] = '{
         9'h003, 9'h002, 9'h001, 9'h0ff, 9'h002, 9'h001, 9'h100,
         9'h023, 9'h002, 9'h080, 9'h002, 9'h081, 9'h000,
         9'h003, 9'h002, 9'h085,
         9'h003, 9'h022, 9'h082, 9'h000, 9'h001, 9'h07f, 9'h002, 9'h000,
         9'h155,
         9'h103
      };
      dpkfe_pkg::cfg_type settings_list [6];
      int goal;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) push_byte(directed[i][7:0], directed[i][8]);
      wait_drained();

      settings_list[0] = '{8'hdf, 8'h03, 8'h02};
      settings_list[1] = '{8'hff, 8'hff, 8'h00};
      settings_list[2] = '{8'h00, 8'h00, 8'h00};
      settings_list[3] = '{8'hff, 8'h02, 8'h03};
      settings_list[4].tag_mask = 8'($urandom);
      settings_list[4].outer_tag = 8'($urandom) & settings_list[4].tag_mask;
      settings_list[4].value_tag = 8'($urandom) & settings_list[4].tag_mask;
      settings_list[5] = '{dpkfe_pkg::TAG_MASK_RESET, dpkfe_pkg::OUTER_TAG_RESET,
                           dpkfe_pkg::VALUE_TAG_RESET};

      foreach (settings_list[s]) begin
         write_csr(dpkfe_pkg::CSR_TAG_MASK, settings_list[s].tag_mask);
         write_csr(dpkfe_pkg::CSR_OUTER_TAG, settings_list[s].outer_tag);
         write_csr(dpkfe_pkg::CSR_VALUE_TAG, settings_list[s].value_tag);
         goal = queued_bytes + PHASE_BYTES;
         while (queued_bytes < goal) push_sequence();
         wait_drained();
      end

      $display("run covered %0d requests over %0d register writes and %0d tag settings",
               n_requests, n_csr, $size(settings_list) + 1);
      $display("checked %0d content bytes and %0d status results", n_content, n_status);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #(8 * 400000);
      $display("Regression FAIL");
      $finish;
   end

endmodule
